### rtl/mlft_pkg.sv
package mlft_pkg;

  localparam int ADDR_W = 48;
  localparam int PORT_W = 4;
  localparam int MASK_W = 16;
  localparam int CFG_W  = 32;

  // Register index taken from paddr[2]; connected_port_mask is the only register.
  localparam logic REG_CONNECTED_MASK = 1'b0;

  // Word that walks down the cell chain during one search.
  typedef struct packed {
    logic              live;
    logic              src_hit;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } mlft_hop_t;

  // Learn request broadcast to all cells; each cell applies its own enable.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } mlft_wr_t;

endpackage

### rtl/mlft_if.sv
interface mlft_in_if;
  import mlft_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;
  logic [PORT_W-1:0] ingress_port;

  modport source (output valid, output src_addr, output dst_addr, output ingress_port,
                  input ready);
  modport sink   (input valid, input src_addr, input dst_addr, input ingress_port,
                  output ready);
endinterface

interface mlft_out_if;
  import mlft_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] egress_mask;
  logic              flooded;
  logic              learned;
  logic              table_full;

  modport source (output valid, output egress_mask, output flooded, output learned,
                  output table_full, input ready);
  modport sink   (input valid, input egress_mask, input flooded, input learned,
                  input table_full, output ready);
endinterface

### rtl/mlft_cell.sv
module mlft_cell
  import mlft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] src_key,
  input  logic [ADDR_W-1:0] dst_key,
  input  mlft_hop_t         hop_in,
  output mlft_hop_t         hop_out,
  input  logic              we,
  input  mlft_wr_t          wr
);

  logic              entry_valid;
  logic [ADDR_W-1:0] entry_address;
  logic [PORT_W-1:0] entry_port;
  logic              src_match;
  logic              dst_match;

  assign src_match = entry_valid && (entry_address == src_key);
  assign dst_match = entry_valid && (entry_address == dst_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= 1'b0;
      hop_out.live <= 1'b0;
    end else begin
      hop_out.live <= hop_in.live;
      if (we) begin
        entry_valid <= 1'b1;
      end
    end
    if (we) begin
      entry_address <= wr.addr;
      entry_port    <= wr.port;
    end
    hop_out.src_hit  <= hop_in.src_hit | src_match;
    hop_out.dst_hit  <= hop_in.dst_hit | dst_match;
    hop_out.dst_port <= dst_match ? entry_port : hop_in.dst_port;
  end

endmodule

### rtl/mac_learning_forward_table.sv
// Learning bridge address table. Each input word carries a frame's source
// address, destination address and ingress port; each output word carries
// the egress port mask plus the flooded, learned and table_full flags. The
// table is a chain of TABLE_ENTRIES cells, each holding one learned station.
// Both addresses are held steady while a search word walks down the chain one
// cell per clock, picking up the source hit, the destination hit and the
// destination's learned port. When the word leaves the last cell, an unknown
// source is appended at the fill position (or table_full is flagged when all
// entries are in use) and the forwarding decision is made; a frame whose
// destination equals its just-learned source finds its own ingress port.
// One frame is in flight at a time; the next frame is accepted only after
// its search word has left the last cell and its result has been loaded.
// The output register lets a finished word wait while the next frame is
// accepted. Entry valid bits are cleared directly by reset, so the table is
// usable on the first cycle after reset. Learned entries never age. Bits of
// egress_mask at or above PORT_COUNT are always zero. connected_port_mask
// sits at byte address 0 of the APB port and may only be written while the
// table is idle.
module mac_learning_forward_table
  import mlft_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int PORT_COUNT    = 16
) (
  input  logic              clk,
  input  logic              rst,
  mlft_in_if.sink           in_ch,
  mlft_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration register.
  logic [MASK_W-1:0] connected_port_mask;

  // Frame under search; the keys stay stable for the whole walk.
  logic [ADDR_W-1:0] src_key;
  logic [ADDR_W-1:0] dst_key;
  logic [PORT_W-1:0] ingress;
  logic              start;

  logic [FILL_W-1:0] fill_count;

  // Result waiting for the output register.
  logic [MASK_W-1:0] res_mask;
  logic              res_flooded;
  logic              res_learned;
  logic              res_full;

  mlft_hop_t         hop [TABLE_ENTRIES+1];
  mlft_hop_t         tail;
  mlft_wr_t          wr;
  logic              learn_we;

  logic              accept;
  logic              src_miss;
  logic              room;
  logic              dst_known;
  logic [PORT_W-1:0] dst_port;
  logic [MASK_W-1:0] limit_mask;
  logic [MASK_W-1:0] mask_next;
  logic              cfg_write;
  logic              out_load;

  // APB port: always ready, one register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[1:0] == 2'b00)
                     && (paddr[2] == REG_CONNECTED_MASK);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CONNECTED_MASK) begin
      prdata = {{(CFG_W - MASK_W){1'b0}}, connected_port_mask};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected_port_mask <= '0;
    end else if (cfg_write) begin
      connected_port_mask <= pwdata[MASK_W-1:0];
    end
  end

  // Ports the table may ever forward to.
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      limit_mask[i] = (i < PORT_COUNT);
    end
  end

  // No frame is taken while reset is held.
  assign in_ch.ready = (state == ST_IDLE) && !rst;
  assign accept      = in_ch.valid && in_ch.ready;

  // The search word enters the chain in the cycle after acceptance, once the
  // keys are registered.
  assign hop[0] = '{live: start, src_hit: 1'b0, dst_hit: 1'b0, dst_port: '0};
  assign tail   = hop[TABLE_ENTRIES];

  assign wr.addr = src_key;
  assign wr.port = ingress;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      mlft_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .src_key (src_key),
        .dst_key (dst_key),
        .hop_in  (hop[g]),
        .hop_out (hop[g+1]),
        .we      (learn_we && (fill_count == FILL_W'(g))),
        .wr      (wr)
      );
    end
  endgenerate

  // Decision at the end of the chain. The destination also matches a source
  // that is being learned in this same cycle.
  assign src_miss  = !tail.src_hit;
  assign room      = (fill_count != FILL_W'(TABLE_ENTRIES));
  assign learn_we  = (state == ST_SEARCH) && tail.live && src_miss && room;
  assign dst_known = tail.dst_hit || (src_miss && room && (dst_key == src_key));
  assign dst_port  = tail.dst_hit ? tail.dst_port : ingress;

  always_comb begin
    if (dst_known) begin
      mask_next = (MASK_W'(1) << dst_port) & limit_mask;
    end else begin
      mask_next = connected_port_mask & ~(MASK_W'(1) << ingress) & limit_mask;
    end
  end

  // A finished result moves to the output register once that register is
  // empty or is being emptied in the same cycle.
  assign out_load = (state == ST_DONE) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      start        <= 1'b0;
      fill_count   <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      start <= accept;
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (tail.live) begin
            state <= ST_DONE;
            if (learn_we) begin
              fill_count <= fill_count + FILL_W'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_key <= in_ch.src_addr;
      dst_key <= in_ch.dst_addr;
      ingress <= in_ch.ingress_port;
    end
    if ((state == ST_SEARCH) && tail.live) begin
      res_mask    <= mask_next;
      res_flooded <= !dst_known;
      res_learned <= src_miss && room;
      res_full    <= src_miss && !room;
    end
    if (out_load) begin
      out_ch.egress_mask <= res_mask;
      out_ch.flooded     <= res_flooded;
      out_ch.learned     <= res_learned;
      out_ch.table_full  <= res_full;
    end
  end

endmodule

### rtl/mlft_checker.sv
module mlft_checker
  import mlft_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [MASK_W-1:0] egress_mask,
  input logic              flooded,
  input logic              learned,
  input logic              table_full
);

  // A waiting output word holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(egress_mask) && $stable(flooded)
      && $stable(learned) && $stable(table_full))
    else $error("output word changed while stalled");

  // One frame at a time: input closes right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second frame accepted during a search");

  // A frame cannot both learn its source and find the table full.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(learned && table_full))
    else $error("learned and table_full both set");

  // A known destination goes to at most one port.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !flooded |-> $onehot0(egress_mask))
    else $error("known destination sent to several ports");

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .egress_mask (out_ch.egress_mask),
  .flooded     (out_ch.flooded),
  .learned     (out_ch.learned),
  .table_full  (out_ch.table_full)
);
